### rtl/cdts_pkg.sv
// ============================================================================
// cdts_pkg
// Types and constants shared by the date and time setting sequencer.
// ============================================================================
package cdts_pkg;

    // Button event codes carried in the func field of a request.
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_INC   = 2'd1;
    localparam logic [1:0] FUNC_DEC   = 2'd2;
    localparam logic [1:0] FUNC_OK    = 2'd3;

    // Wrap limits of the edited fields.
    localparam logic [6:0] YEAR_MAX   = 7'd99;
    localparam logic [3:0] MONTH_MIN  = 4'd1;
    localparam logic [3:0] MONTH_MAX  = 4'd12;
    localparam logic [4:0] DAY_MIN    = 5'd1;
    localparam logic [4:0] HOUR_MAX   = 5'd23;
    localparam logic [5:0] MINUTE_MAX = 6'd59;
    localparam logic [3:0] FEBRUARY   = 4'd2;
    localparam logic [4:0] LEAP_FEB   = 5'd29;
    localparam logic [4:0] LONG_MONTH = 5'd31;

    typedef struct packed {
        logic [1:0] func;
        logic [6:0] load_year;
        logic [3:0] load_month;
        logic [4:0] load_day;
        logic [4:0] load_hour;
        logic [5:0] load_minute;
    } cdts_req_t;

    typedef struct packed {
        logic [2:0] stage;
        logic [6:0] shown_value;
        logic       done_res;
        logic [6:0] out_year;
        logic [3:0] out_month;
        logic [4:0] out_day;
        logic [4:0] out_hour;
        logic [5:0] out_minute;
    } cdts_rsp_t;

    // Length of a month, with February at 29 in years divisible by four.
    // A month code outside 1 to 12 gives 31.
    function automatic logic [4:0] month_len(input logic [3:0] month,
                                             input logic [6:0] year);
        logic [4:0] len;
        begin
            unique case (month)
                4'd2:                    len = 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
                default:                 len = LONG_MONTH;
            endcase
            if (month == FEBRUARY && year[1:0] == 2'b00)
            begin
                len = LEAP_FEB;
            end
            return len;
        end
    endfunction

endpackage

### rtl/clock_date_time_setter.sv
// ============================================================================
// clock_date_time_setter
// Steps through year, month, day, hour and minute on button events and
// reports the edited date and time after the final ok.
// ============================================================================
// A request accepted at a clock edge has its response registered at that edge.
// Throughput: one request per cycle; the response register takes a new value
// whenever it is empty or being drained in the same cycle.
// Reset: the sequencer returns to idle with year 0, month 1, day 1, hour 0,
// minute 0 and a month length of 31, and the response register is emptied.
module clock_date_time_setter
    import cdts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  cdts_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output cdts_rsp_t rsp
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_YEAR   = 3'd1,
        ST_MONTH  = 3'd2,
        ST_DAY    = 3'd3,
        ST_HOUR   = 3'd4,
        ST_MINUTE = 3'd5
    } stage_t;

    stage_t     stage_reg, stage_next;
    logic [6:0] year_reg, year_next;
    logic [3:0] month_reg, month_next;
    logic [4:0] day_reg, day_next;
    logic [4:0] hour_reg, hour_next;
    logic [5:0] minute_reg, minute_next;
    logic [4:0] mlen_reg, mlen_next;
    logic       done_next;
    logic [6:0] shown_next;
    logic       rsp_valid_reg;
    cdts_rsp_t  rsp_reg;
    logic       accept;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        stage_next  = stage_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        mlen_next   = mlen_reg;
        done_next   = 1'b0;

        unique case (stage_reg)
            ST_YEAR, ST_MONTH, ST_DAY, ST_HOUR, ST_MINUTE:
            begin
                unique case (req.func)
                    FUNC_INC:
                    begin
                        unique case (stage_reg)
                            ST_YEAR:   year_next = (year_reg < YEAR_MAX) ?
                                                   year_reg + 7'd1 : 7'd0;
                            ST_MONTH:  month_next = (month_reg < MONTH_MAX) ?
                                                    month_reg + 4'd1 : MONTH_MIN;
                            ST_DAY:    day_next = (day_reg < mlen_reg) ?
                                                  day_reg + 5'd1 : DAY_MIN;
                            ST_HOUR:   hour_next = (hour_reg < HOUR_MAX) ?
                                                   hour_reg + 5'd1 : 5'd0;
                            default:   minute_next = (minute_reg < MINUTE_MAX) ?
                                                     minute_reg + 6'd1 : 6'd0;
                        endcase
                    end
                    FUNC_DEC:
                    begin
                        unique case (stage_reg)
                            ST_YEAR:   year_next = (year_reg > 7'd0) ?
                                                   year_reg - 7'd1 : YEAR_MAX;
                            ST_MONTH:  month_next = (month_reg > MONTH_MIN) ?
                                                    month_reg - 4'd1 : MONTH_MAX;
                            ST_DAY:    day_next = (day_reg > DAY_MIN) ?
                                                  day_reg - 5'd1 : mlen_reg;
                            ST_HOUR:   hour_next = (hour_reg > 5'd0) ?
                                                   hour_reg - 5'd1 : HOUR_MAX;
                            default:   minute_next = (minute_reg > 6'd0) ?
                                                     minute_reg - 6'd1 : MINUTE_MAX;
                        endcase
                    end
                    FUNC_OK:
                    begin
                        if (stage_reg == ST_MONTH)
                        begin
                            mlen_next = month_len(month_reg, year_reg);
                        end
                        if (stage_reg == ST_MINUTE)
                        begin
                            stage_next = ST_IDLE;
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            stage_next = stage_t'(stage_reg + 3'd1);
                        end
                    end
                    default:
                    begin
                        // A start while editing changes nothing.
                    end
                endcase
            end
            default:
            begin
                stage_next = ST_IDLE;
                if (req.func == FUNC_START)
                begin
                    year_next   = req.load_year;
                    month_next  = req.load_month;
                    day_next    = req.load_day;
                    hour_next   = req.load_hour;
                    minute_next = req.load_minute;
                    stage_next  = ST_YEAR;
                end
            end
        endcase

        unique case (stage_next)
            ST_YEAR:   shown_next = year_next;
            ST_MONTH:  shown_next = {3'd0, month_next};
            ST_DAY:    shown_next = {2'd0, day_next};
            ST_HOUR:   shown_next = {2'd0, hour_next};
            ST_MINUTE: shown_next = {1'b0, minute_next};
            default:   shown_next = 7'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg     <= ST_IDLE;
            year_reg      <= 7'd0;
            month_reg     <= MONTH_MIN;
            day_reg       <= DAY_MIN;
            hour_reg      <= 5'd0;
            minute_reg    <= 6'd0;
            mlen_reg      <= LONG_MONTH;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                stage_reg  <= stage_next;
                year_reg   <= year_next;
                month_reg  <= month_next;
                day_reg    <= day_next;
                hour_reg   <= hour_next;
                minute_reg <= minute_next;
                mlen_reg   <= mlen_next;
            end
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // The response register holds only payload and needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= '{stage:       stage_next,
                         shown_value: shown_next,
                         done_res:    done_next,
                         out_year:    year_next,
                         out_month:   month_next,
                         out_day:     day_next,
                         out_hour:    hour_next,
                         out_minute:  minute_next};
        end
    end

    // A completed setting always leaves the sequencer idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.done_res |-> rsp.stage == ST_IDLE)
        else $error("done reported outside idle");

    // Nothing is shown while idle.
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.stage == ST_IDLE |-> rsp.shown_value == 7'd0)
        else $error("nonzero value shown while idle");

    // A start accepted while idle enters year editing.
    a_start_year: assert property (@(posedge clk) disable iff (!rst_n)
        accept && stage_reg == ST_IDLE && req.func == FUNC_START
        |=> stage_reg == ST_YEAR && rsp_valid && rsp.stage == ST_YEAR)
        else $error("start did not enter year editing");

    // Ok on the minute produces a done response.
    a_minute_ok: assert property (@(posedge clk) disable iff (!rst_n)
        accept && stage_reg == ST_MINUTE && req.func == FUNC_OK
        |=> rsp_valid && rsp.done_res)
        else $error("final ok did not report done");

endmodule

### tb/sv/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the date and time setting sequencer. A queue of
// button requests feeds a valid/ready driver, and a predictor tracks the
// edit state to build the expected response for every accepted request. A
// monitor compares each response field by field. The sender and the receiver
// idle in random bursts, and once the receiver holds off long enough for the
// block to back up and stall its input.
// ============================================================================
module tb_top
    import cdts_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_YEAR   = 3'd1,
        ST_MONTH  = 3'd2,
        ST_DAY    = 3'd3,
        ST_HOUR   = 3'd4,
        ST_MINUTE = 3'd5
    } edit_stage_e;

    localparam int TARGET_REQS = 1600;
    localparam int TAIL_REQS   = 150;
    localparam int HOLD_CYCLES = 300;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    cdts_req_t req       = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    cdts_rsp_t rsp;

    clock_date_time_setter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #1 clk = ~clk;

    // Pending requests, and the responses they are predicted to cause.
    cdts_req_t pending_req[$];
    cdts_rsp_t expected_rsp[$];
    cdts_rsp_t next_rsp;

    int total_reqs    = 0;
    int accepted_reqs = 0;
    int fail_count    = 0;
    int sessions_seen = 0;
    int commits_seen  = 0;
    int leap_febs     = 0;
    int stall_cycles  = 0;

    // Shadow copy of the sequencer state.
    edit_stage_e sim_stage = ST_IDLE;
    logic [6:0]  sim_year  = 7'd0;
    logic [3:0]  sim_month = 4'd1;
    logic [4:0]  sim_day   = 5'd1;
    logic [4:0]  sim_hour  = 5'd0;
    logic [5:0]  sim_min   = 6'd0;
    logic [4:0]  sim_mlen  = LONG_MONTH;

    logic [31:0] cyc       = '0;
    logic        tail_flag = 1'b0;
    logic        hold_rsp  = 1'b0;
    logic [4:0]  req_gap   = '0;
    logic [4:0]  rsp_gap   = '0;

    // Idling pauses in every fourth window selected by cyc[9:8] and in the tail.
    wire quiet = tail_flag || (cyc[9:8] == 2'b11);

    function automatic logic [6:0] wrap_up(input logic [6:0] v, input logic [6:0] lo,
                                           input logic [6:0] hi);
        return (v < hi) ? v + 7'd1 : lo;
    endfunction

    function automatic logic [6:0] wrap_down(input logic [6:0] v, input logic [6:0] lo,
                                             input logic [6:0] hi);
        return (v > lo) ? v - 7'd1 : hi;
    endfunction

    task automatic advance_setter(input cdts_req_t r, output cdts_rsp_t o);
        logic       commit;
        logic       up;
        logic [6:0] shown;
        begin
            commit = 1'b0;
            up     = (r.func == FUNC_INC);
            if (!(sim_stage >= ST_YEAR && sim_stage <= ST_MINUTE))
            begin
                sim_stage = ST_IDLE;
                if (r.func == FUNC_START)
                begin
                    sim_year  = r.load_year;
                    sim_month = r.load_month;
                    sim_day   = r.load_day;
                    sim_hour  = r.load_hour;
                    sim_min   = r.load_minute;
                    sim_stage = ST_YEAR;
                    sessions_seen++;
                end
            end
            else if (r.func == FUNC_INC || r.func == FUNC_DEC)
            begin
                case (sim_stage)
                    ST_YEAR:   sim_year  = up ? wrap_up(sim_year, 7'd0, YEAR_MAX)
                                              : wrap_down(sim_year, 7'd0, YEAR_MAX);
                    ST_MONTH:  sim_month = 4'(up ?
                                   wrap_up(7'(sim_month), 7'(MONTH_MIN), 7'(MONTH_MAX)) :
                                   wrap_down(7'(sim_month), 7'(MONTH_MIN), 7'(MONTH_MAX)));
                    ST_DAY:    sim_day   = 5'(up ?
                                   wrap_up(7'(sim_day), 7'(DAY_MIN), 7'(sim_mlen)) :
                                   wrap_down(7'(sim_day), 7'(DAY_MIN), 7'(sim_mlen)));
                    ST_HOUR:   sim_hour  = 5'(up ?
                                   wrap_up(7'(sim_hour), 7'd0, 7'(HOUR_MAX)) :
                                   wrap_down(7'(sim_hour), 7'd0, 7'(HOUR_MAX)));
                    ST_MINUTE: sim_min   = 6'(up ?
                                   wrap_up(7'(sim_min), 7'd0, 7'(MINUTE_MAX)) :
                                   wrap_down(7'(sim_min), 7'd0, 7'(MINUTE_MAX)));
                    default:   ;
                endcase
            end
            else if (r.func == FUNC_OK)
            begin
                if (sim_stage == ST_MONTH)
                begin
                    case (sim_month)
                        4'd2:                    sim_mlen = 5'd28;
                        4'd4, 4'd6, 4'd9, 4'd11: sim_mlen = 5'd30;
                        default:                 sim_mlen = 5'd31;
                    endcase
                    if (sim_month == FEBRUARY && sim_year[1:0] == 2'b00)
                    begin
                        sim_mlen = LEAP_FEB;
                        leap_febs++;
                    end
                end
                if (sim_stage == ST_MINUTE)
                begin
                    sim_stage = ST_IDLE;
                    commit    = 1'b1;
                    commits_seen++;
                end
                else
                begin
                    sim_stage = edit_stage_e'(sim_stage + 3'd1);
                end
            end
            case (sim_stage)
                ST_YEAR:   shown = sim_year;
                ST_MONTH:  shown = {3'd0, sim_month};
                ST_DAY:    shown = {2'd0, sim_day};
                ST_HOUR:   shown = {2'd0, sim_hour};
                ST_MINUTE: shown = {1'd0, sim_min};
                default:   shown = 7'd0;
            endcase
            o.stage       = sim_stage;
            o.shown_value = shown;
            o.done_res    = commit;
            o.out_year    = sim_year;
            o.out_month   = sim_month;
            o.out_day     = sim_day;
            o.out_hour    = sim_hour;
            o.out_minute  = sim_min;
        end
    endtask

    task automatic compare_rsp(input cdts_rsp_t want, input cdts_rsp_t got);
        begin
            if (got.stage !== want.stage)
            begin
                $error("stage: expected %0d, got %0d", want.stage, got.stage);
                fail_count++;
            end
            if (got.shown_value !== want.shown_value)
            begin
                $error("shown_value: expected %0d, got %0d", want.shown_value, got.shown_value);
                fail_count++;
            end
            if (got.done_res !== want.done_res)
            begin
                $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
                fail_count++;
            end
            if (got.out_year !== want.out_year)
            begin
                $error("out_year: expected %0d, got %0d", want.out_year, got.out_year);
                fail_count++;
            end
            if (got.out_month !== want.out_month)
            begin
                $error("out_month: expected %0d, got %0d", want.out_month, got.out_month);
                fail_count++;
            end
            if (got.out_day !== want.out_day)
            begin
                $error("out_day: expected %0d, got %0d", want.out_day, got.out_day);
                fail_count++;
            end
            if (got.out_hour !== want.out_hour)
            begin
                $error("out_hour: expected %0d, got %0d", want.out_hour, got.out_hour);
                fail_count++;
            end
            if (got.out_minute !== want.out_minute)
            begin
                $error("out_minute: expected %0d, got %0d", want.out_minute, got.out_minute);
                fail_count++;
            end
        end
    endtask

    task automatic queue_req(input logic [1:0] f, input logic [6:0] y, input logic [3:0] m,
                             input logic [4:0] d, input logic [4:0] h, input logic [5:0] mi);
        cdts_req_t r;
        begin
            r.func        = f;
            r.load_year   = y;
            r.load_month  = m;
            r.load_day    = d;
            r.load_hour   = h;
            r.load_minute = mi;
            pending_req.push_back(r);
            total_reqs++;
        end
    endtask

    // A button event that is not a start carries junk in the load fields.
    task automatic queue_button(input logic [1:0] f);
        begin
            queue_req(f, 7'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
                      6'($urandom));
        end
    endtask

    // Mostly plausible dates, and now and then anything the field widths allow.
    task automatic queue_start();
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                queue_req(FUNC_START, 7'($urandom), 4'($urandom), 5'($urandom),
                          5'($urandom), 6'($urandom));
            end
            else
            begin
                queue_req(FUNC_START, 7'($urandom_range(0, 99)), 4'($urandom_range(1, 12)),
                          5'($urandom_range(1, 31)), 5'($urandom_range(0, 23)),
                          6'($urandom_range(0, 59)));
            end
        end
    endtask

    task automatic build_directed();
        begin
            // Buttons while idle are ignored.
            queue_button(FUNC_INC);
            queue_button(FUNC_DEC);
            queue_button(FUNC_OK);
            queue_req(FUNC_START, 7'd99, 4'd12, 5'd31, 5'd23, 6'd59);
            queue_button(FUNC_INC);
            queue_button(FUNC_DEC);
            // A start while editing changes nothing.
            queue_req(FUNC_START, 7'd5, 4'd5, 5'd5, 5'd5, 6'd5);
            queue_button(FUNC_OK);
            queue_button(FUNC_INC);
            queue_button(FUNC_DEC);
            queue_button(FUNC_OK);
            queue_button(FUNC_INC);
            queue_button(FUNC_DEC);
            queue_button(FUNC_OK);
            queue_button(FUNC_INC);
            queue_button(FUNC_DEC);
            queue_button(FUNC_OK);
            queue_button(FUNC_INC);
            queue_button(FUNC_DEC);
            queue_button(FUNC_OK);
            // Leap February with a loaded day above the month length.
            queue_req(FUNC_START, 7'd0, FEBRUARY, 5'd31, 5'd0, 6'd0);
            queue_button(FUNC_OK);
            queue_button(FUNC_OK);
            queue_button(FUNC_INC);
            queue_button(FUNC_DEC);
        end
    endtask

    task automatic build_random();
        int session_reqs;
        int steps;
        int last_stage;
        begin
            session_reqs = 0;
            while (session_reqs < TARGET_REQS)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    repeat ($urandom_range(1, 3)) queue_button(2'($urandom_range(1, 3)));
                end
                queue_start();
                session_reqs++;
                // Now and then a session is cut short and the next start lands mid-edit.
                last_stage = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 5;
                for (int s = 1; s <= last_stage; s++)
                begin
                    steps = ($urandom_range(0, 14) == 0) ? $urandom_range(50, 130)
                                                         : $urandom_range(0, 5);
                    repeat (steps)
                    begin
                        if ($urandom_range(0, 19) == 0)
                        begin
                            queue_button(FUNC_START);
                        end
                        queue_button($urandom_range(0, 1) ? FUNC_INC : FUNC_DEC);
                        session_reqs++;
                    end
                    queue_button(FUNC_OK);
                    session_reqs++;
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        cyc       <= cyc + 32'd1;
        tail_flag <= (pending_req.size() < TAIL_REQS);
    end

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            req_gap   <= '0;
        end
        else
        begin
            if (req_valid && !req_ready)
            begin
                stall_cycles++;
            end
            if (req_valid && req_ready)
            begin
                advance_setter(req, next_rsp);
                expected_rsp.push_back(next_rsp);
                accepted_reqs++;
            end
            if (!req_valid || req_ready)
            begin
                if (req_gap != 0)
                begin
                    req_gap   <= req_gap - 5'd1;
                    req_valid <= 1'b0;
                end
                else if (!quiet && $urandom_range(0, 9) == 0)
                begin
                    req_gap   <= 5'($urandom_range(0, 16));
                    req_valid <= 1'b0;
                end
                else if (pending_req.size() != 0)
                begin
                    req       <= pending_req.pop_front();
                    req_valid <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor and receiver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            rsp_gap   <= '0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $error("response with no request waiting for it");
                    fail_count++;
                end
                else
                begin
                    compare_rsp(expected_rsp.pop_front(), rsp);
                end
            end
            if (hold_rsp)
            begin
                rsp_ready <= 1'b0;
            end
            else if (rsp_gap != 0)
            begin
                rsp_gap   <= rsp_gap - 5'd1;
                rsp_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                rsp_gap   <= 5'($urandom_range(0, 16));
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // One long receiver hold-off so that the response register backs up.
    initial
    begin
        @(posedge clk);
        while (accepted_reqs < 400) @(posedge clk);
        hold_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp <= 1'b0;
    end

    initial
    begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        build_directed();
        build_random();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        while (accepted_reqs < total_reqs || expected_rsp.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Ran %0d requests through %0d edit sessions, %0d committed, %0d leap Februaries.",
                 accepted_reqs, sessions_seen, commits_seen, leap_febs);
        $display("The input was held back for %0d cycles by a full response stage.", stall_cycles);
        if (fail_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
